// ===== hw/rtl/qfe_pkg.sv =====
// ----------------------------------------------------------------------------
// qfe_pkg - shared constants and types of the endpoint quaternion block
// Field widths, register reset value and the result class code.
// ----------------------------------------------------------------------------
package qfe_pkg;

	localparam int COORD_W = 32;                  // signed Q16.16 coordinate
	localparam int QUAT_W  = 18;                  // quaternion component
	localparam int THR_W   = 17;                  // cosine limit register
	localparam int MAG_W   = 32;                  // normalised magnitude
	localparam logic [THR_W-1:0] THR_RESET = 17'd65529;

	// class of a direction after the cosine test
	typedef enum logic [1:0] {
		CLS_GENERAL,
		CLS_IDENT,
		CLS_HALF
	} qfe_class_t;

endpackage

// ===== hw/rtl/qfe_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// qfe_sqrt_pipe - pipelined integer square root
// Floor square root, one result bit per stage, with a sideband carried along.
// ----------------------------------------------------------------------------
module qfe_sqrt_pipe #(
	parameter int IW = 64,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [SW-1:0]   out_side
);

	localparam int RW = IW / 2;

	logic [RW-1:0] valid_s;
	logic [RW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [IW-1:0] rad_s  [RW];
	logic [SW-1:0] side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [IW-1:0] rad_in;
		logic [SW-1:0] side_in;
		logic          v_in;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = valid_s[k-1];
		end

		// bring down the next two radicand bits and try 4*root+1
		assign cur   = {rem_in, rad_in[IW-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
				root_s[k] <= {root_in[RW-2:0], ge};
				rad_s[k]  <= {rad_in[IW-3:0], 2'b00};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

// ===== hw/rtl/qfe_div_pipe.sv =====
// ----------------------------------------------------------------------------
// qfe_div_pipe - pipelined restoring divider
// One quotient bit per stage; the caller guarantees num < den << QW.
// ----------------------------------------------------------------------------
module qfe_div_pipe #(
	parameter int NW = 50,
	parameter int DW = 32,
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quot,
	output logic [SW-1:0] out_side
);

	logic [QW-1:0] valid_s;
	logic [DW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [QW-1:0] quot_s [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] low_in;
		logic [QW-1:0] quot_in;
		logic [SW-1:0] side_in;
		logic          v_in;
		logic [DW:0]   cur;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			// upper part is below the divisor by the caller's bound
			assign rem_in  = in_num[QW +: DW];
			assign low_in  = in_num[QW-1:0];
			assign den_in  = in_den;
			assign quot_in = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign low_in  = low_s[k-1];
			assign den_in  = den_s[k-1];
			assign quot_in = quot_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = valid_s[k-1];
		end

		assign cur  = {rem_in, low_in[QW-1]};
		assign ge   = cur >= {1'b0, den_in};
		assign diff = cur - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
				den_s[k]  <= den_in;
				low_s[k]  <= {low_in[QW-2:0], 1'b0};
				quot_s[k] <= {quot_in[QW-2:0], ge};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_quot  = quot_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== hw/rtl/quaternion_from_endpoints.sv =====
// ----------------------------------------------------------------------------
// quaternion_from_endpoints - shortest-arc quaternion from +z onto a segment
// Turns a start/end point pair into the unit quaternion rotating +z onto the
// direction end - start, with parallel, antiparallel and zero-length cases.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: start_x..end_z, 6 x 32 bits
//  m_*      out  tvalid/tready      tdata: quat_w..quat_z, 4 x 18; tuser: zero_length
//  cfg_*    in   cfg_we             cfg_wdata: parallel_threshold, 17 bits
//
//  One request enters per cycle while the result is not stalled; the pipeline is
//  built from the stages s1..s10, the 32-stage square root of |d|^2 and three FRAC_BITS+1
//  stage units (cosine divider, half-angle square roots, axis dividers).
//  Reset clears every valid bit and loads the threshold with its reset value.
//  A stalled result freezes the whole pipeline; an input skid register keeps
//  s_tready registered and catches the request taken in the stall cycle.
// ----------------------------------------------------------------------------
module quaternion_from_endpoints #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [qfe_pkg::THR_W-1:0] cfg_wdata,    // parallel_threshold
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [191:0]              s_tdata,      // start_x, start_y, start_z, end_x, end_y, end_z
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [71:0]               m_tdata,      // quat_w, quat_x, quat_y, quat_z
	output logic [0:0]                m_tuser       // zero_length
);

	localparam int CW  = qfe_pkg::COORD_W;
	localparam int MW  = qfe_pkg::MAG_W;
	localparam int OW  = qfe_pkg::QUAT_W;
	localparam int F   = FRAC_BITS;
	localparam int QW  = F + 1;                     // capped ratio / root width
	localparam int NW  = F + 34;                    // dividend width
	localparam int AW  = 2 * F + 2;                 // half-angle radicand width
	localparam int PW  = MW + QW;                   // axis product width
	localparam int CPW = ((F + 2) > (qfe_pkg::THR_W + 1) ? (F + 2) : (qfe_pkg::THR_W + 1)) + 1;
	localparam logic [QW-1:0]  ONE_Q = QW'(1) << F;
	localparam logic [CPW-1:0] ONE_C = CPW'(1) << F;
	localparam logic [OW-1:0]  ONE_O = OW'(ONE_Q);

	typedef struct packed {
		logic          zero;
		logic [2:0]    neg;
		logic [MW-1:0] mag2;
	} side_r_t;

	typedef struct packed {
		logic [MW-1:0] mag1;
		logic [MW-1:0] mag0;
	} side_rxy_t;

	typedef struct packed {
		logic          zero;
		logic [2:0]    neg;
		logic [MW-1:0] mag1;
		logic [MW-1:0] mag0;
		logic [MW-1:0] rxy;
	} side_c_t;

	typedef struct packed {
		qfe_pkg::qfe_class_t cls;
		logic                zero;
		logic [1:0]          neg;
	} side_w_t;

	typedef struct packed {
		logic [MW-1:0] mag1;
		logic [MW-1:0] mag0;
		logic [MW-1:0] rxy;
	} side_s_t;

	typedef struct packed {
		logic [QW-1:0]       qw;
		qfe_pkg::qfe_class_t cls;
		logic                zero;
		logic [1:0]          neg;
	} side_x_t;

	typedef struct packed {
		logic [QW-1:0] s;
		logic          rxyz;
	} side_y_t;

	// ---------------------------------------------------------------- config
	logic [qfe_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qfe_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------- advance and input skid
	logic         adv;          // whole pipeline moves one step
	logic         in_take;
	logic         skid_v_q;
	logic [191:0] skid_q;
	logic         pin_valid;
	logic [191:0] pin_data;

	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = !skid_v_q;
	assign in_take   = s_tvalid && s_tready;
	assign pin_valid = skid_v_q || in_take;
	assign pin_data  = skid_v_q ? skid_q : s_tdata;

	// park a request taken while the pipeline holds; drain it on the next advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (adv) begin
			skid_v_q <= 1'b0;
		end else if (in_take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_take) begin
			skid_q <= s_tdata;
		end
	end

	// --------------------------------------------------- s1: difference vector
	logic                 v_s1;
	logic signed [CW:0]   d_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= (CW+1)'($signed(pin_data[(i+3)*CW +: CW]))
				         - (CW+1)'($signed(pin_data[i*CW +: CW]));
			end
		end
	end

	// --------------------------------------------------- s2: sign and magnitude
	logic          v_s2;
	logic [2:0]    neg_s2;
	logic [CW:0]   mag_s2 [3];
	logic          zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= d_s1[i][CW];
				mag_s2[i] <= d_s1[i][CW] ? (CW+1)'(-d_s1[i]) : (CW+1)'(d_s1[i]);
			end
			zero_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
		end
	end

	// ------------------------------------------ s3: largest magnitude, shift
	logic        v_s3;
	logic [2:0]  neg_s3;
	logic [CW:0] mag_s3 [3];
	logic        zero_s3;
	logic        rsh_s3;
	logic [4:0]  lsh_s3;
	logic [CW:0] m01;
	logic [CW:0] mmax;
	logic [4:0]  msb;

	always_comb begin
		m01  = (mag_s2[1] > mag_s2[0]) ? mag_s2[1] : mag_s2[0];
		mmax = (mag_s2[2] > m01) ? mag_s2[2] : m01;
		msb  = '0;
		for (int j = 0; j < CW; j++) begin
			if (mmax[j]) begin
				msb = 5'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			zero_s3 <= zero_s2;
			// right by one above 2^31, else left until the top reaches bit 30
			rsh_s3  <= mmax > ((CW+1)'(1) << (CW - 1));
			lsh_s3  <= (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
		end
	end

	// ---------------------------------------------------- s4: normalise
	logic          v_s4;
	logic [2:0]    neg_s4;
	logic [MW-1:0] nm_s4 [3];
	logic          zero_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nm_s4[i] <= rsh_s3 ? MW'(mag_s3[i] >> 1) : MW'(mag_s3[i] << lsh_s3);
			end
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
		end
	end

	// ---------------------------------------------------- s5: squares
	logic          v_s5;
	logic [2:0]    neg_s5;
	logic [MW-1:0] nm_s5 [3];
	logic [63:0]   sq_s5 [3];
	logic          zero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= 64'(nm_s4[i]) * 64'(nm_s4[i]);
			end
			nm_s5   <= nm_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	// ---------------------------------------------------- s6: sums of squares
	logic          v_s6;
	logic [63:0]   sum3_s6;
	logic [63:0]   sumxy_s6;
	side_r_t       sr_s6;
	side_rxy_t     sxy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum3_s6     <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			sumxy_s6    <= sq_s5[0] + sq_s5[1];
			sr_s6.zero  <= zero_s5;
			sr_s6.neg   <= neg_s5;
			sr_s6.mag2  <= nm_s5[2];
			sxy_s6.mag1 <= nm_s5[1];
			sxy_s6.mag0 <= nm_s5[0];
		end
	end

	// ------------------------------------------------ vector lengths
	logic          r_valid;
	logic [MW-1:0] r_len;
	side_r_t       r_side;
	logic          rxy_valid;
	logic [MW-1:0] rxy_len;
	side_rxy_t     rxy_side;

	qfe_sqrt_pipe #(.IW(64), .SW($bits(side_r_t))) u_sqrt_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s6),
		.in_rad    (sum3_s6),
		.in_side   (sr_s6),
		.out_valid (r_valid),
		.out_root  (r_len),
		.out_side  (r_side)
	);

	qfe_sqrt_pipe #(.IW(64), .SW($bits(side_rxy_t))) u_sqrt_rxy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s6),
		.in_rad    (sumxy_s6),
		.in_side   (sxy_s6),
		.out_valid (rxy_valid),
		.out_root  (rxy_len),
		.out_side  (rxy_side)
	);

	// ------------------------------------------------ cosine: |dz| / r rounded
	logic          c_valid;
	logic [QW-1:0] c_quot;
	side_c_t       c_side_in;
	side_c_t       c_side;
	logic [NW-1:0] c_num;

	assign c_num          = (NW'(r_side.mag2) << F) + NW'(r_len >> 1);
	assign c_side_in.zero = r_side.zero;
	assign c_side_in.neg  = r_side.neg;
	assign c_side_in.mag1 = rxy_side.mag1;
	assign c_side_in.mag0 = rxy_side.mag0;
	assign c_side_in.rxy  = rxy_len;

	qfe_div_pipe #(.NW(NW), .DW(MW), .QW(QW), .SW($bits(side_c_t))) u_div_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (r_valid),
		.in_num    (c_num),
		.in_den    (r_len),
		.in_side   (c_side_in),
		.out_valid (c_valid),
		.out_quot  (c_quot),
		.out_side  (c_side)
	);

	// ------------------------------------------------ s7: signed cosine
	logic                v_s7;
	logic signed [F+1:0] c_s7;
	side_c_t             sc_s7;
	logic [QW-1:0]       cmag;

	assign cmag = (c_quot > ONE_Q) ? ONE_Q : c_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s7  <= c_side.neg[2] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
			sc_s7 <= c_side;
		end
	end

	// ------------------------------------------ s8: classify, half-angle args
	logic                 v_s8;
	logic [AW-1:0]        aw_s8;
	logic [AW-1:0]        as_s8;
	side_w_t              sw_s8;
	side_s_t              ss_s8;
	logic signed [CPW-1:0] c_ext;
	logic signed [CPW-1:0] thr_ext;
	logic signed [CPW-1:0] sum_w;
	logic signed [CPW-1:0] sum_s;
	qfe_pkg::qfe_class_t  cls;

	always_comb begin
		c_ext   = CPW'(c_s7);
		thr_ext = CPW'($signed({1'b0, thr_q}));
		sum_w   = $signed(ONE_C) + c_ext;
		sum_s   = $signed(ONE_C) - c_ext;
		if (c_ext > thr_ext) begin
			cls = qfe_pkg::CLS_IDENT;
		end else if (c_ext < -thr_ext) begin
			cls = qfe_pkg::CLS_HALF;
		end else begin
			cls = qfe_pkg::CLS_GENERAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aw_s8      <= AW'({sum_w[F+1:0], {(F-1){1'b0}}});
			as_s8      <= AW'({sum_s[F+1:0], {(F-1){1'b0}}});
			sw_s8.cls  <= cls;
			sw_s8.zero <= sc_s7.zero;
			sw_s8.neg  <= sc_s7.neg[1:0];
			ss_s8.mag1 <= sc_s7.mag1;
			ss_s8.mag0 <= sc_s7.mag0;
			ss_s8.rxy  <= sc_s7.rxy;
		end
	end

	// ------------------------------------------------ half-angle cos and sin
	logic          w_valid;
	logic [QW-1:0] w_root;
	side_w_t       w_side;
	logic          s_valid;
	logic [QW-1:0] s_root;
	side_s_t       s_side;

	qfe_sqrt_pipe #(.IW(AW), .SW($bits(side_w_t))) u_sqrt_w (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.in_rad    (aw_s8),
		.in_side   (sw_s8),
		.out_valid (w_valid),
		.out_root  (w_root),
		.out_side  (w_side)
	);

	qfe_sqrt_pipe #(.IW(AW), .SW($bits(side_s_t))) u_sqrt_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.in_rad    (as_s8),
		.in_side   (ss_s8),
		.out_valid (s_valid),
		.out_root  (s_root),
		.out_side  (s_side)
	);

	// ------------------------------------------------ s9: axis products
	logic          v_s9;
	logic [PW-1:0] px_s9;
	logic [PW-1:0] py_s9;
	logic [MW-1:0] rxy_s9;
	side_x_t       sx_s9;
	side_y_t       sy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= w_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s9      <= PW'(s_side.mag1) * PW'(s_root);
			py_s9      <= PW'(s_side.mag0) * PW'(s_root);
			rxy_s9     <= s_side.rxy;
			sx_s9.qw   <= w_root;
			sx_s9.cls  <= w_side.cls;
			sx_s9.zero <= w_side.zero;
			sx_s9.neg  <= w_side.neg;
			sy_s9.s    <= s_root;
			sy_s9.rxyz <= s_side.rxy == '0;
		end
	end

	// ------------------------------------------------ axis components
	logic          x_valid;
	logic [QW-1:0] x_quot;
	side_x_t       x_side;
	logic          y_valid;
	logic [QW-1:0] y_quot;
	side_y_t       y_side;
	logic [NW-1:0] x_num;
	logic [NW-1:0] y_num;

	assign x_num = NW'(px_s9) + NW'(rxy_s9 >> 1);
	assign y_num = NW'(py_s9) + NW'(rxy_s9 >> 1);

	qfe_div_pipe #(.NW(NW), .DW(MW), .QW(QW), .SW($bits(side_x_t))) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.in_num    (x_num),
		.in_den    (rxy_s9),
		.in_side   (sx_s9),
		.out_valid (x_valid),
		.out_quot  (x_quot),
		.out_side  (x_side)
	);

	qfe_div_pipe #(.NW(NW), .DW(MW), .QW(QW), .SW($bits(side_y_t))) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.in_num    (y_num),
		.in_den    (rxy_s9),
		.in_side   (sy_s9),
		.out_valid (y_valid),
		.out_quot  (y_quot),
		.out_side  (y_side)
	);

	// ------------------------------------------------ s10: result register
	logic                v_s10;
	logic [OW-1:0]       qw_s10;
	logic [OW-1:0]       qx_s10;
	logic [OW-1:0]       qy_s10;
	logic                zl_s10;
	logic [QW-1:0]       axc;
	logic [QW-1:0]       ayc;
	logic signed [F+1:0] axs;
	logic signed [F+1:0] ays;
	logic signed [F+1:0] qx_g;
	logic signed [F+1:0] qy_g;
	logic [OW-1:0]       qw_n;
	logic [OW-1:0]       qx_n;
	logic [OW-1:0]       qy_n;

	always_comb begin
		axc = (x_quot > ONE_Q) ? ONE_Q : x_quot;
		ayc = (y_quot > ONE_Q) ? ONE_Q : y_quot;
		axs = $signed({1'b0, axc});
		ays = $signed({1'b0, ayc});
		// x follows -dy, y follows dx; a vertical axis falls back to y
		if (y_side.rxyz) begin
			qx_g = '0;
			qy_g = $signed({1'b0, y_side.s});
		end else begin
			qx_g = x_side.neg[1] ? axs : -axs;
			qy_g = x_side.neg[0] ? -ays : ays;
		end
		qw_n = OW'(x_side.qw);
		qx_n = OW'(qx_g);
		qy_n = OW'(qy_g);
		if (x_side.zero) begin
			qw_n = ONE_O;
			qx_n = '0;
			qy_n = '0;
		end else begin
			case (x_side.cls)
				qfe_pkg::CLS_IDENT: begin
					qw_n = ONE_O;
					qx_n = '0;
					qy_n = '0;
				end
				qfe_pkg::CLS_HALF: begin
					qw_n = '0;
					qx_n = '0;
					qy_n = ONE_O;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= x_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qw_s10 <= qw_n;
			qx_s10 <= qx_n;
			qy_s10 <= qy_n;
			zl_s10 <= x_side.zero;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {{OW{1'b0}}, qy_s10, qx_s10, qw_s10};
	assign m_tuser  = zl_s10;

	// ------------------------------------------------ checks
	a_len_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid == rxy_valid)
		else $error("length lanes out of step");

	a_half_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		w_valid == s_valid)
		else $error("half-angle lanes out of step");

	a_axis_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid == y_valid)
		else $error("axis lanes out of step");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> !$past(adv))
		else $error("skid filled while pipeline advanced");

	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[OW-1:0] == ONE_O && m_tdata[71:OW] == '0))
		else $error("zero-length result is not the identity");

endmodule
